>>> rtl/core/ulpa_pkg.sv
package ulpa_pkg;

	localparam int DEF_MAX_PRB     = 128;
	localparam int DEF_MAX_RBG     = 32;
	localparam int DEF_NUM_TENANTS = 4;

	localparam int WORD_W      = 32;
	localparam int MASK_W      = 32;
	localparam int CFG_TENANTS = 4;
	localparam int CFG_IDX_W   = 3;

	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_ALLOC = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PRB  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RBG_SIZE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_RBG  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TENANT0  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TENANT1  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TENANT2  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TENANT3  = 3'd6;

	localparam logic [6:0] NUM_PRB_RST  = 7'd100;
	localparam logic [2:0] RBG_SIZE_RST = 3'd4;
	localparam logic [4:0] NUM_RBG_RST  = 5'd25;

	localparam logic [6:0] EDGE_PRBS = 7'd3;

	localparam int NUM_DFT = 37;
	localparam logic [6:0] DFT_SIZES [NUM_DFT] = '{
		7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd8, 7'd9, 7'd10, 7'd12,
		7'd15, 7'd16, 7'd18, 7'd20, 7'd24, 7'd25, 7'd27, 7'd30, 7'd32, 7'd36,
		7'd40, 7'd45, 7'd48, 7'd50, 7'd54, 7'd60, 7'd64, 7'd72, 7'd75, 7'd80,
		7'd81, 7'd90, 7'd96, 7'd100, 7'd108, 7'd120, 7'd125
	};

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  slice_id;
		logic        use_slice;
		logic [6:0]  req_len;
		logic [1:0]  word_index;
		logic [31:0] word_data;
	} cmd_t;

	typedef struct packed {
		logic [6:0] grant_start;
		logic [6:0] grant_len;
		logic       found;
		logic       met;
	} rsp_t;

	typedef struct packed {
		logic scan_init;
		logic mark_init;
		logic step;
		logic scan;
		logic mark;
		logic trim;
	} pass_ctrl_t;

	function automatic logic [6:0] dft_trim(input logic [6:0] len);
		logic [6:0] r;
		r = 7'd0;
		for (int k = 0; k < NUM_DFT; k++) begin
			if (DFT_SIZES[k] <= len) r = DFT_SIZES[k];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/ulpa_map.sv
module ulpa_map
	import ulpa_pkg::*;
#(
	parameter int MAX_PRB = DEF_MAX_PRB
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clr,
	input  logic        load,
	input  logic [1:0]  word_index,
	input  logic [31:0] word_data,
	input  pass_ctrl_t  ctrl,
	input  logic        grant,
	output logic        cur
);

	logic [MAX_PRB-1:0] map_q;
	logic [MAX_PRB-1:0] load_sel;
	logic [MAX_PRB-1:0] load_bit;

	for (genvar p = 0; p < MAX_PRB; p++) begin : g_word
		assign load_sel[p] = (word_index == 2'(p / WORD_W));
		assign load_bit[p] = word_data[p % WORD_W];
	end

	assign cur = map_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (clr) begin
			map_q <= '0;
		end else if (load) begin
			map_q <= (map_q & ~load_sel) | (load_bit & load_sel);
		end else if (ctrl.step) begin
			map_q <= {map_q[0] | grant, map_q[MAX_PRB-1:1]};
		end
	end

endmodule

>>> rtl/core/ulpa_rbg.sv
module ulpa_rbg
	import ulpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  pass_ctrl_t        ctrl,
	input  logic [2:0]        rbg_size,
	input  logic [5:0]        nrbg,
	input  logic              use_slice,
	input  logic              slice_valid,
	input  logic [MASK_W-1:0] mask,
	input  logic              live,
	input  logic              blocked,
	input  logic              hit_en,
	output logic              slice_block,
	output logic [MASK_W-1:0] hit
);

	logic [5:0]        idx_q;
	logic [2:0]        off_q;
	logic [MASK_W-1:0] mask_q;
	logic [MASK_W-1:0] hit_q;
	logic              in_rbg;

	assign in_rbg      = (rbg_size != 3'd0) && (idx_q < nrbg);
	assign slice_block = use_slice && (!slice_valid || (in_rbg && !mask_q[0]));
	assign hit         = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			off_q <= '0;
		end else if (ctrl.scan_init || ctrl.mark_init) begin
			idx_q <= '0;
			off_q <= '0;
		end else if (ctrl.step && in_rbg) begin
			if (off_q == 3'(rbg_size - 3'd1)) begin
				off_q <= '0;
				idx_q <= idx_q + 6'd1;
			end else begin
				off_q <= off_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan_init || ctrl.mark_init) begin
			mask_q <= mask;
			hit_q  <= '0;
		end else if (ctrl.step && in_rbg) begin
			if (hit_en && ctrl.mark && live && blocked) hit_q[idx_q[4:0]] <= 1'b1;
			if (off_q == 3'(rbg_size - 3'd1)) mask_q <= {1'b0, mask_q[MASK_W-1:1]};
		end
	end

endmodule

>>> rtl/core/ulpa_run.sv
module ulpa_run
	import ulpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  pass_ctrl_t ctrl,
	input  logic       live,
	input  logic       blocked,
	input  logic [6:0] prb,
	input  logic [6:0] req_len,
	output logic [6:0] run_start,
	output logic [6:0] run_len
);

	logic [6:0] start_q;
	logic [6:0] len_q;
	logic       stop_q;
	logic       active;

	assign active    = ctrl.step && ctrl.scan && live && (len_q < req_len) && !stop_q;
	assign run_start = start_q;
	assign run_len   = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			len_q   <= '0;
			stop_q  <= 1'b0;
		end else if (ctrl.scan_init) begin
			start_q <= '0;
			len_q   <= '0;
			stop_q  <= 1'b0;
		end else if (ctrl.trim) begin
			len_q <= dft_trim(len_q);
		end else if (active) begin
			if (!blocked) begin
				if (len_q == 7'd0) start_q <= prb;
				len_q <= len_q + 7'd1;
			end else if (len_q != 7'd0) begin
				if (prb < EDGE_PRBS) begin
					start_q <= '0;
					len_q   <= '0;
				end else begin
					stop_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/core/ul_contiguous_prb_allocator_core.sv
// Channel   Transfer when            Payload
// command   start & !busy            cmd (cmd_t)
// result    done (one cycle)         rsp (rsp_t)
// config    cfg_valid & cfg_ready    cfg_index, cfg_data
//
// Begin-TTI, load-word and unused commands give their result on the next cycle
// and leave busy low. During an allocation busy is high and the used map, a shift
// ring, is walked one PRB per cycle, once to find the run and, when a run is
// found, once more to mark it.
// arst_n clears the map, the tenant masks and the control state.
// The receiver cannot stall; each result is shown for exactly one cycle.
module ul_contiguous_prb_allocator_core
	import ulpa_pkg::*;
#(
	parameter int MAX_PRB     = DEF_MAX_PRB,
	parameter int MAX_RBG     = DEF_MAX_RBG,
	parameter int NUM_TENANTS = DEF_NUM_TENANTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int CNT_W = $clog2(MAX_PRB);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_TRIM = 5'b00100,
		ST_MARK = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  n_q;
	logic [6:0]        num_prb_q;
	logic [2:0]        rbg_size_q;
	logic [4:0]        num_rbg_q;
	logic [MASK_W-1:0] tmask_q [CFG_TENANTS];
	logic [MASK_W-1:0] avail_q [NUM_TENANTS];
	logic [1:0]        slice_q;
	logic              use_slice_q;
	logic [6:0]        req_len_q;
	logic              done_q;
	rsp_t              rsp_q;

	pass_ctrl_t        ctrl;
	logic              acc;
	logic              pass_end;
	logic [7:0]        nprb;
	logic [5:0]        nrbg;
	logic              live;
	logic [6:0]        prb;
	logic [1:0]        slice_sel;
	logic              slice_valid;
	logic [MASK_W-1:0] mask_sel;
	logic              map_cur;
	logic              grant;
	logic              slice_block;
	logic              blocked;
	logic [MASK_W-1:0] hit;
	logic [6:0]        run_start;
	logic [6:0]        run_len;

	assign busy      = (state_q != ST_IDLE);
	assign acc       = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign pass_end    = (n_q == CNT_W'(MAX_PRB - 1));
	assign nprb        = (8'(num_prb_q) > 8'(MAX_PRB)) ? 8'(MAX_PRB) : 8'(num_prb_q);
	assign nrbg        = (6'(num_rbg_q) > 6'(MAX_RBG)) ? 6'(MAX_RBG) : 6'(num_rbg_q);
	assign live        = (8'(n_q) < nprb);
	assign prb         = 7'(n_q);
	assign slice_sel   = (state_q == ST_IDLE) ? cmd.slice_id : slice_q;
	assign slice_valid = (3'(slice_q) < 3'(NUM_TENANTS));

	always_comb begin
		mask_sel = '0;
		for (int i = 0; i < NUM_TENANTS; i++) begin
			if (slice_sel == 2'(i)) mask_sel = avail_q[i];
		end
	end

	always_comb begin
		ctrl.scan_init = acc && (cmd.action == ACT_ALLOC);
		ctrl.mark_init = (state_q == ST_TRIM) && (run_len != 7'd0);
		ctrl.trim      = ctrl.mark_init;
		ctrl.step      = (state_q == ST_SCAN) || (state_q == ST_MARK);
		ctrl.scan      = (state_q == ST_SCAN);
		ctrl.mark      = (state_q == ST_MARK);
	end

	assign grant = ctrl.mark && ({1'b0, prb} >= {1'b0, run_start}) &&
		({1'b0, prb} < ({1'b0, run_start} + {1'b0, run_len}));
	assign blocked = map_cur || grant || slice_block;

	ulpa_map #(
		.MAX_PRB(MAX_PRB)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (acc && (cmd.action == ACT_BEGIN)),
		.load      (acc && (cmd.action == ACT_LOAD)),
		.word_index(cmd.word_index),
		.word_data (cmd.word_data),
		.ctrl      (ctrl),
		.grant     (grant),
		.cur       (map_cur)
	);

	ulpa_rbg u_rbg (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.rbg_size   (rbg_size_q),
		.nrbg       (nrbg),
		.use_slice  (use_slice_q),
		.slice_valid(slice_valid),
		.mask       (mask_sel),
		.live       (live),
		.blocked    (blocked),
		.hit_en     (use_slice_q && slice_valid),
		.slice_block(slice_block),
		.hit        (hit)
	);

	ulpa_run u_run (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.live     (live),
		.blocked  (blocked),
		.prb      (prb),
		.req_len  (req_len_q),
		.run_start(run_start),
		.run_len  (run_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_prb_q  <= NUM_PRB_RST;
			rbg_size_q <= RBG_SIZE_RST;
			num_rbg_q  <= NUM_RBG_RST;
			for (int i = 0; i < CFG_TENANTS; i++) tmask_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NUM_PRB:  num_prb_q  <= cfg_data[6:0];
				CFG_RBG_SIZE: rbg_size_q <= cfg_data[2:0];
				CFG_NUM_RBG:  num_rbg_q  <= cfg_data[4:0];
				CFG_TENANT0:  tmask_q[0] <= cfg_data;
				CFG_TENANT1:  tmask_q[1] <= cfg_data;
				CFG_TENANT2:  tmask_q[2] <= cfg_data;
				CFG_TENANT3:  tmask_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < NUM_TENANTS; i++) avail_q[i] <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						n_q <= '0;
						if (cmd.action == ACT_ALLOC) begin
							state_q <= ST_SCAN;
						end else begin
							done_q <= 1'b1;
						end
						if (cmd.action == ACT_BEGIN) begin
							for (int i = 0; i < NUM_TENANTS; i++) begin
								if (i < CFG_TENANTS) avail_q[i] <= tmask_q[i];
							end
						end
					end
				end
				ST_SCAN: begin
					n_q <= pass_end ? '0 : n_q + CNT_W'(1);
					if (pass_end) state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					if (run_len == 7'd0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					n_q <= pass_end ? '0 : n_q + CNT_W'(1);
					if (pass_end) state_q <= ST_DONE;
				end
				ST_DONE: begin
					for (int i = 0; i < NUM_TENANTS; i++) begin
						if (use_slice_q && (slice_q == 2'(i))) avail_q[i] <= avail_q[i] & ~hit;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			slice_q     <= cmd.slice_id;
			use_slice_q <= cmd.use_slice;
			req_len_q   <= cmd.req_len;
			rsp_q       <= '0;
		end else if (state_q == ST_TRIM && run_len == 7'd0) begin
			rsp_q <= '0;
		end else if (state_q == ST_DONE) begin
			rsp_q.grant_start <= run_start;
			rsp_q.grant_len   <= run_len;
			rsp_q.found       <= 1'b1;
			rsp_q.met         <= (run_len == req_len_q);
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ulpa_pkg::*;

	localparam logic [1:0]           ACT_SPARE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;
	localparam int                   QUIET_LIMIT = 2000;
	localparam int                   PHASE_ITEMS = 115;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	cmd_t                 cmd       = '0;
	logic                 done;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;

	ul_contiguous_prb_allocator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [6:0]   cell_prb       = NUM_PRB_RST;
	logic [2:0]   cell_rbg_size  = RBG_SIZE_RST;
	logic [4:0]   cell_rbg_count = NUM_RBG_RST;
	logic [31:0]  cell_mask [4]  = '{default: '0};
	logic [127:0] used_map       = '0;
	logic [31:0]  slice_avail [4] = '{default: '0};

	cmd_t cmd_q [$];
	rsp_t grant_q [$];
	logic steady = 1'b0;
	int   n_queued = 0;
	int   n_sent = 0;
	int   n_checked = 0;
	int   n_granted = 0;
	int   n_mismatch = 0;
	int   n_settings = 0;
	int   quiet = 0;

	function automatic rsp_t predict_grant(cmd_t c);
		rsp_t         r;
		logic [127:0] blk;
		logic [31:0]  mask;
		logic         hit;
		int           nprb, nrbg, rsz, req, st, len, m, n, i, j;
		logic         ok;
		r    = '0;
		nprb = int'(cell_prb);
		nrbg = int'(cell_rbg_count);
		rsz  = int'(cell_rbg_size);
		req  = int'(c.req_len);
		case (c.action)
			ACT_BEGIN: begin
				used_map = '0;
				for (i = 0; i < 4; i++) slice_avail[i] = cell_mask[i];
			end
			ACT_LOAD: begin
				for (j = 0; j < 32; j++) used_map[int'(c.word_index) * 32 + j] = c.word_data[j];
			end
			ACT_ALLOC: begin
				blk = '0;
				for (n = 0; n < nprb; n++) blk[n] = used_map[n];
				if (c.use_slice) begin
					mask = slice_avail[c.slice_id];
					for (i = 0; i < nrbg; i++) begin
						if (!mask[i]) begin
							for (j = 0; j < rsz && i * rsz + j < nprb; j++) blk[i * rsz + j] = 1'b1;
						end
					end
				end
				st  = 0;
				len = 0;
				for (n = 0; n < nprb && len < req; n++) begin
					if (!blk[n]) begin
						if (len == 0) st = n;
						len++;
					end else if (len > 0) begin
						if (n < int'(EDGE_PRBS)) begin
							st  = 0;
							len = 0;
						end else begin
							break;
						end
					end
				end
				if (len > 0) begin
					ok = 1'b0;
					while (!ok) begin
						m = len;
						while (m % 2 == 0) m = m / 2;
						while (m % 3 == 0) m = m / 3;
						while (m % 5 == 0) m = m / 5;
						if (m == 1) ok = 1'b1;
						else len--;
					end
					for (n = st; n < st + len; n++) begin
						used_map[n] = 1'b1;
						blk[n]      = 1'b1;
					end
					if (c.use_slice) begin
						for (i = 0; i < nrbg; i++) begin
							hit = 1'b0;
							for (j = 0; j < rsz && i * rsz + j < nprb; j++) begin
								if (blk[i * rsz + j]) hit = 1'b1;
							end
							if (hit) slice_avail[c.slice_id][i] = 1'b0;
						end
					end
					r.grant_start = st[6:0];
					r.grant_len   = len[6:0];
					r.found       = 1'b1;
					r.met         = (len == req);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_t make_cmd(int act, int sl, int us, int req, int wi, logic [31:0] wd);
		cmd_t c;
		c.action     = act[1:0];
		c.slice_id   = sl[1:0];
		c.use_slice  = us[0];
		c.req_len    = req[6:0];
		c.word_index = wi[1:0];
		c.word_data  = wd;
		return c;
	endfunction

	function automatic logic [31:0] pick_mask();
		case ($urandom_range(4))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0;
			2: return $urandom | $urandom;
			3: return $urandom & $urandom;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_cmd(cmd_t c);
		cmd_q.push_back(c);
		n_queued++;
	endtask

	task automatic queue_tti(int nprb);
		logic [63:0] raw;
		logic [31:0] wd;
		int          req, top, k;
		top = (nprb > 0) ? nprb : 1;
		if ($urandom_range(9) != 0)
			queue_cmd(make_cmd(ACT_BEGIN, $urandom_range(3), $urandom_range(1),
				$urandom_range(127), $urandom_range(3), $urandom));
		repeat ($urandom_range(3)) begin
			case ($urandom_range(4))
				0: wd = 32'h0;
				1: wd = $urandom;
				2: wd = $urandom & $urandom & $urandom;
				3: wd = ~($urandom & $urandom & $urandom);
				default: wd = 32'h1 << $urandom_range(31);
			endcase
			queue_cmd(make_cmd(ACT_LOAD, $urandom_range(3), $urandom_range(1),
				$urandom_range(127), $urandom_range(3), wd));
		end
		repeat ($urandom_range(1, 8)) begin
			k = $urandom_range(99);
			if (k < 5) req = 0;
			else if (k < 15) req = $urandom_range(127);
			else if (k < 35) req = $urandom_range(1, top);
			else req = $urandom_range(1, 16);
			queue_cmd(make_cmd(ACT_ALLOC, $urandom_range(3), $urandom_range(1), req,
				$urandom_range(3), $urandom));
			if ($urandom_range(19) == 0) begin
				raw = {$urandom, $urandom};
				queue_cmd(raw[$bits(cmd_t)-1:0]);
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_NUM_PRB:  cell_prb       = val[6:0];
			CFG_RBG_SIZE: cell_rbg_size  = val[2:0];
			CFG_NUM_RBG:  cell_rbg_count = val[4:0];
			CFG_TENANT0:  cell_mask[0]   = val;
			CFG_TENANT1:  cell_mask[1]   = val;
			CFG_TENANT2:  cell_mask[2]   = val;
			CFG_TENANT3:  cell_mask[3]   = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic program_cell(int nprb, int rsz, int nrbg,
		logic [31:0] m0, logic [31:0] m1, logic [31:0] m2, logic [31:0] m3);
		write_reg(CFG_SPARE, $urandom);
		write_reg(CFG_NUM_PRB, ($urandom & ~32'h7F) | (nprb & 32'h7F));
		write_reg(CFG_RBG_SIZE, ($urandom & ~32'h7) | (rsz & 32'h7));
		write_reg(CFG_NUM_RBG, ($urandom & ~32'h1F) | (nrbg & 32'h1F));
		write_reg(CFG_TENANT0, m0);
		write_reg(CFG_TENANT1, m1);
		write_reg(CFG_TENANT2, m2);
		write_reg(CFG_TENANT3, m3);
		n_settings++;
	endtask

	task automatic drain();
		@(negedge clk);
		while (cmd_q.size() != 0 || start || grant_q.size() != 0 || busy) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				grant_q.push_back(predict_grant(cmd));
				n_sent++;
			end
			if (!start || !busy) begin
				if (cmd_q.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
					cmd   <= cmd_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string why, rsp_t want, rsp_t got);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("%s: expected start %0d len %0d found %0b met %0b, got start %0d len %0d found %0b met %0b",
				why, want.grant_start, want.grant_len, want.found, want.met,
				got.grant_start, got.grant_len, got.found, got.met);
	endtask

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (grant_q.size() == 0) begin
					report_mismatch("unexpected result", '0, rsp);
				end else begin
					want = grant_q.pop_front();
					n_checked++;
					if (want.found) n_granted++;
					if (rsp.grant_start !== want.grant_start || rsp.grant_len !== want.grant_len ||
						rsp.found !== want.found || rsp.met !== want.met)
						report_mismatch($sformatf("result %0d", n_checked), want, rsp);
				end
			end
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					quiet, grant_q.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int p, quota, nprb, rsz, nrbg;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_cell(100, 4, 25, 32'hFFFF_FFFF, 32'h00F0_F0F0, 32'h0, $urandom);
		queue_cmd(make_cmd(ACT_BEGIN, 0, 0, 0, 0, 32'h0));
		queue_cmd(make_cmd(ACT_ALLOC, 0, 0, 0, 0, 32'h0));
		queue_cmd(make_cmd(ACT_ALLOC, 0, 0, 1, 0, 32'h0));
		queue_cmd(make_cmd(ACT_ALLOC, 0, 0, 7, 0, 32'h0));
		queue_cmd(make_cmd(ACT_ALLOC, 0, 0, 127, 3, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(ACT_BEGIN, 3, 1, 127, 3, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(ACT_LOAD, 0, 0, 0, 0, 32'h0000_0002));
		queue_cmd(make_cmd(ACT_ALLOC, 0, 0, 10, 0, 32'h0));
		queue_cmd(make_cmd(ACT_LOAD, 0, 0, 0, 0, 32'h0000_0010));
		queue_cmd(make_cmd(ACT_ALLOC, 0, 0, 10, 0, 32'h0));
		queue_cmd(make_cmd(ACT_LOAD, 0, 0, 0, 1, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(ACT_LOAD, 0, 0, 0, 2, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(ACT_LOAD, 0, 0, 0, 3, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(ACT_LOAD, 0, 0, 0, 0, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(ACT_ALLOC, 0, 0, 5, 0, 32'h0));
		queue_cmd(make_cmd(ACT_SPARE, 3, 1, 127, 3, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(ACT_BEGIN, 0, 0, 0, 0, 32'h0));
		queue_cmd(make_cmd(ACT_ALLOC, 2, 1, 20, 0, 32'h0));
		queue_cmd(make_cmd(ACT_ALLOC, 1, 1, 20, 0, 32'h0));
		queue_cmd(make_cmd(ACT_ALLOC, 0, 1, 127, 0, 32'h0));
		queue_cmd(make_cmd(ACT_ALLOC, 3, 0, 3, 0, 32'h0));
		queue_cmd(make_cmd(ACT_ALLOC, 1, 1, 127, 0, 32'h0));
		drain();

		for (p = 1; p <= 8; p++) begin
			case (p)
				1: begin nprb = 6;   rsz = 1; nrbg = 1;  end
				2: begin nprb = 127; rsz = 7; nrbg = 31; end
				3: begin nprb = 100; rsz = 4; nrbg = 25; end
				4: begin nprb = 50;  rsz = 0; nrbg = 15; end
				5, 8: begin
					rsz  = $urandom_range(1, 4);
					nprb = $urandom_range(6, 100);
					nrbg = (nprb + rsz - 1) / rsz;
					if (nrbg > 31) nrbg = 31;
				end
				7: begin nprb = 25; rsz = 1; nrbg = 25; end
				default: begin
					nprb = $urandom_range(127);
					rsz  = $urandom_range(7);
					nrbg = $urandom_range(31);
				end
			endcase
			program_cell(nprb, rsz, nrbg, pick_mask(), pick_mask(), pick_mask(), pick_mask());
			steady = (p == 3);
			quota = n_queued + PHASE_ITEMS;
			while (n_queued < quota) queue_tti(nprb);
			drain();
		end
		steady = 1'b0;
		repeat (300) @(posedge clk);

		$display("covered %0d commands under %0d cell settings: %0d results checked, %0d grants",
			n_sent, n_settings, n_checked, n_granted);
		$display("%0d mismatches, %0d results outstanding", n_mismatch, grant_q.size());
		if (n_mismatch == 0 && grant_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ulpa_pkg.sv
rtl/core/ulpa_map.sv
rtl/core/ulpa_rbg.sv
rtl/core/ulpa_run.sv
rtl/core/ul_contiguous_prb_allocator_core.sv
test/testbench.sv
